// ----- design/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and helpers of the season segment detector.
// ----------------------------------------------------------------------------
package ssd_pkg;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int LEN_W  = 40;     // twice a time, with room for 3a - b and differences
    localparam int IDX_W  = 13;     // holds any series length up to 4096
    localparam int CNT_W  = 9;

    // Defaults of the top-level parameters
    localparam int SERIES_LEN_DEF  = 256;
    localparam int MAX_SEASONS_DEF = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_LEN   = 2'd1;
    localparam logic [1:0] REG_LOW_MODE  = 2'd2;
    localparam logic [1:0] REG_MAX_SEAS  = 2'd3;

    localparam logic [CNT_W-1:0] CNT_SAT = '1;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               sample_null;
        logic signed [31:0] sample_time;
        logic               last_sample;
    } t_sample;

    typedef struct packed {
        logic        [3:0]  season_index;
        logic signed [31:0] start_core;
        logic signed [31:0] start_extended;
        logic signed [31:0] end_core;
        logic signed [31:0] end_extended;
        logic               is_summary;
        logic        [8:0]  season_count;
        logic               all_null;
        logic               last_result;
    } t_result;

    typedef struct packed {
        logic signed [31:0] threshold_level;
        logic        [30:0] min_length;
        logic               low_mode;
        logic        [4:0]  max_seasons;
    } t_cfg;

    // Store write from the loader
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   addr;
        logic signed [31:0] value;
        logic               nul;
        logic signed [31:0] tim;
    } t_wr;

    // Search request from the loader
    typedef struct packed {
        logic             go;
        logic [IDX_W-1:0] n;
        logic             all_null;
    } t_start;

    // Sign-extend a time to the length width
    function automatic logic signed [LEN_W-1:0] sx(input logic signed [31:0] t);
        sx = {{(LEN_W-32){t[31]}}, t};
    endfunction

endpackage

// ----- design/season_segment_detector_core.sv -----
// ----------------------------------------------------------------------------
// season_segment_detector_core
// Season search over one pixel's time series, with a sample loader in front
// and a result queue behind the search sequencer.
// ----------------------------------------------------------------------------
// Usage: send the samples of one series as input transactions, one per cycle
// while o_in_ready is high; last_sample marks the final one. Up to SERIES_LEN
// samples are kept, later ones are dropped. After the last sample the loader
// holds o_in_ready low while the search walks the store. Each entry of a pass
// takes a store read and then an evaluation, and an entry can be visited by
// the core run, the backward and the forward extension passes. Season
// transactions and then one summary transaction leave on the output channel
// through a two-entry queue; when the receiver stalls the queue fills and the
// search holds. Configuration writes take effect at once; they are to be done
// between series by the user, as the block does not enforce it. Reset clears
// the loader, search and queue control and returns the registers to defaults;
// the store needs no clearing.
// ----------------------------------------------------------------------------
module season_segment_detector_core import ssd_pkg::*; #(
    parameter int SERIES_LEN  = SERIES_LEN_DEF,
    parameter int MAX_SEASONS = MAX_SEASONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_sample     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out_data
);
    t_cfg    r_cfg;
    t_wr     wr;
    t_start  start;
    logic    done, push, push_ready;
    t_result push_data;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_level <= '0;
            r_cfg.min_length      <= 31'd65536;
            r_cfg.low_mode        <= 1'b0;
            r_cfg.max_seasons     <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_THRESHOLD: r_cfg.threshold_level <= i_cfg_wdata;
                REG_MIN_LEN:   r_cfg.min_length      <= i_cfg_wdata[30:0];
                REG_LOW_MODE:  r_cfg.low_mode        <= i_cfg_wdata[0];
                REG_MAX_SEAS:  r_cfg.max_seasons     <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    ssd_front #(.SERIES_LEN(SERIES_LEN)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_wr       (wr),
        .o_start    (start),
        .i_done     (done)
    );

    ssd_search #(.SERIES_LEN(SERIES_LEN), .MAX_SEASONS(MAX_SEASONS)) u_search (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_wr         (wr),
        .i_start      (start),
        .o_done       (done),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    ssd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// ----- design/ssd_front.sv -----
// ----------------------------------------------------------------------------
// ssd_front
// Sample loader: takes sample transactions, writes them to the store, keeps
// the fill count and the all-null flag, and hands the series to the search.
// ----------------------------------------------------------------------------
module ssd_front import ssd_pkg::*; #(
    parameter int SERIES_LEN = SERIES_LEN_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_sample i_in_data,
    output t_wr     o_wr,
    output t_start  o_start,
    input  logic    i_done
);
    localparam int CW = $clog2(SERIES_LEN + 1);
    localparam logic [CW-1:0] FULL = CW'(SERIES_LEN);
    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_WAIT = 1'b1;

    logic          r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_nulls, n_nulls;
    t_start        r_start, n_start;
    logic          accept, store;

    assign o_in_ready = (r_st == ST_LOAD);
    assign accept     = i_in_valid && o_in_ready;
    assign store      = accept && (r_cnt < FULL);

    // Drive the store write port
    always_comb begin
        o_wr.we    = store;
        o_wr.addr  = IDX_W'(r_cnt);
        o_wr.value = i_in_data.sample_value;
        o_wr.nul   = i_in_data.sample_null;
        o_wr.tim   = i_in_data.sample_time;
    end

    // Advance count, hand off on the last sample, wait for the search
    always_comb begin
        n_st       = r_st;
        n_cnt      = r_cnt;
        n_nulls    = r_nulls;
        n_start    = r_start;
        n_start.go = 1'b0;
        case (r_st)
            ST_LOAD: begin
                if (store) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_nulls = r_nulls & i_in_data.sample_null;
                end
                if (accept && i_in_data.last_sample) begin
                    n_start.go       = 1'b1;
                    n_start.n        = IDX_W'(n_cnt);
                    n_start.all_null = n_nulls;
                    n_st             = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_done) begin
                    n_cnt   = '0;
                    n_nulls = 1'b1;
                    n_st    = ST_LOAD;
                end
            end
            default: n_st = ST_LOAD;
        endcase
    end

    // Hold loader state; the start count and all-null flag take no reset value
    always_ff @(posedge i_clk) begin
        r_start.n        <= n_start.n;
        r_start.all_null <= n_start.all_null;
        if (!i_rst_n) begin
            r_st       <= ST_LOAD;
            r_cnt      <= '0;
            r_nulls    <= 1'b1;
            r_start.go <= 1'b0;
        end else begin
            r_st       <= n_st;
            r_cnt      <= n_cnt;
            r_nulls    <= n_nulls;
            r_start.go <= n_start.go;
        end
    end

    assign o_start = r_start;

    // No sample taken while a search runs
    a_no_load_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_WAIT) |-> !store) else $error("store written during search");
    a_go_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start.go |-> (r_st == ST_WAIT)) else $error("search start outside wait");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL) else $error("fill count beyond store depth");

endmodule

// ----- design/ssd_queue.sv -----
// ----------------------------------------------------------------------------
// ssd_queue
// Two-entry result queue between the search and the output channel.
// ----------------------------------------------------------------------------
module ssd_queue import ssd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    output logic    o_push_ready,
    input  t_result i_push_data,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);
    t_result    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_out_valid  = (r_cnt != 2'd0);
    assign o_out_data   = r_mem[r_rp];
    assign wr           = i_push && o_push_ready;
    assign rd           = o_out_valid && i_out_ready;

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue overfilled");
    a_fill_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> (r_cnt == $past(r_cnt) + 2'd1)) else $error("fill level lost a push");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp)) else $error("pointers out of step");

endmodule

// ----- design/ssd_search.sv -----
// ----------------------------------------------------------------------------
// ssd_search
// Sample store and season search sequencer. Walks the stored series with a
// store read and an evaluation per entry: core run, backward extension,
// forward extension, then pushes season and summary results to the queue.
// ----------------------------------------------------------------------------
module ssd_search import ssd_pkg::*; #(
    parameter int SERIES_LEN  = SERIES_LEN_DEF,
    parameter int MAX_SEASONS = MAX_SEASONS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_wr     i_wr,
    input  t_start  i_start,
    output logic    o_done,
    output logic    o_push,
    input  logic    i_push_ready,
    output t_result o_push_data
);
    localparam int AW = $clog2(SERIES_LEN);
    localparam int CW = $clog2(SERIES_LEN + 1);
    localparam logic [CNT_W-1:0] MAXS = CNT_W'(MAX_SEASONS);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_P0    = 5'd1;
    localparam logic [4:0] S_P1    = 5'd2;
    localparam logic [4:0] S_P2    = 5'd3;
    localparam logic [4:0] S_P3    = 5'd4;
    localparam logic [4:0] S_P4    = 5'd5;
    localparam logic [4:0] S_C_LD  = 5'd6;
    localparam logic [4:0] S_C_CAP = 5'd7;
    localparam logic [4:0] S_C_RD  = 5'd8;
    localparam logic [4:0] S_C_EV  = 5'd9;
    localparam logic [4:0] S_B_LD  = 5'd10;
    localparam logic [4:0] S_B_CAP = 5'd11;
    localparam logic [4:0] S_B_RD  = 5'd12;
    localparam logic [4:0] S_B_EV  = 5'd13;
    localparam logic [4:0] S_F_LD  = 5'd14;
    localparam logic [4:0] S_F_CAP = 5'd15;
    localparam logic [4:0] S_F_RD  = 5'd16;
    localparam logic [4:0] S_F_EV  = 5'd17;
    localparam logic [4:0] S_EMIT  = 5'd18;
    localparam logic [4:0] S_SUM   = 5'd19;

    // Sample store
    logic signed [31:0] r_vmem [SERIES_LEN];
    logic signed [31:0] r_tmem [SERIES_LEN];
    logic               r_nmem [SERIES_LEN];
    logic signed [31:0] r_rd_v, r_rd_t;
    logic               r_rd_nl;
    logic [AW-1:0]      rd_addr;

    // Sequencer state
    logic [4:0]             r_state;
    logic [CW-1:0]          r_n, r_i, r_i0, r_s1, r_e1, r_e2;
    logic                   r_nulls, r_run, r_gap;
    logic [CNT_W-1:0]       r_found;
    logic signed [31:0]     r_cur_v, r_cur_t, r_aux_t, r_t0, r_tl;
    logic                   r_cur_nl;
    logic signed [31:0]     r_ts1, r_ts2, r_te1, r_te2;
    logic signed [LEN_W-1:0] r_e0, r_el, r_mark;

    logic                    ins, first_i, last_i, hit, stopb, stopf, season_ok;
    logic signed [LEN_W-1:0] need, sum_cn, sum_pc, eb_c, ea_c, eb_b, mark_c, mark_b, mark_f;
    logic [CNT_W-1:0]        limit;

    // Write and read the store
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_vmem[i_wr.addr[AW-1:0]] <= i_wr.value;
            r_tmem[i_wr.addr[AW-1:0]] <= i_wr.tim;
            r_nmem[i_wr.addr[AW-1:0]] <= i_wr.nul;
        end
        r_rd_v  <= r_vmem[rd_addr];
        r_rd_t  <= r_tmem[rd_addr];
        r_rd_nl <= r_nmem[rd_addr];
    end

    // Select read address per step
    always_comb begin
        case (r_state)
            S_P1:    rd_addr = AW'(1);
            S_P2:    rd_addr = AW'(r_n - 1'b1);
            S_P3:    rd_addr = AW'(r_n - 2'd2);
            S_C_LD:  rd_addr = r_i0[AW-1:0];
            S_C_RD:  rd_addr = AW'(r_i + 1'b1);
            S_B_LD:  rd_addr = AW'(r_s1 - 1'b1);
            S_B_RD:  rd_addr = AW'(r_i - 1'b1);
            S_F_LD:  rd_addr = AW'(r_e1 + 1'b1);
            S_F_RD:  rd_addr = AW'(r_i + 1'b1);
            default: rd_addr = '0;
        endcase
    end

    // Classify and measure around the current entry
    always_comb begin
        need    = LEN_W'({1'b0, i_cfg.min_length, 1'b0});
        ins     = !r_cur_nl && (i_cfg.low_mode ? (r_cur_v <= i_cfg.threshold_level)
                                               : (r_cur_v >= i_cfg.threshold_level));
        first_i = (r_i == '0);
        last_i  = (r_i == r_n - 1'b1);
        sum_cn  = sx(r_cur_t) + sx(r_rd_t);
        sum_pc  = sx(r_aux_t) + sx(r_cur_t);
        eb_c    = first_i ? r_e0 : sum_pc;
        ea_c    = last_i ? r_el : sum_cn;
        eb_b    = first_i ? r_e0 : sum_cn;
        mark_c  = r_run ? r_mark : eb_c;
        mark_b  = r_gap ? r_mark : sum_pc;
        mark_f  = r_gap ? r_mark : sum_pc;
        hit     = ins && (ea_c - mark_c >= need);
        stopb   = !ins && (mark_b - eb_b >= need);
        stopf   = !ins && (ea_c - mark_f >= need);
        limit   = ({4'b0, i_cfg.max_seasons} < MAXS) ? {4'b0, i_cfg.max_seasons} : MAXS;
        season_ok = (r_found < limit);
    end

    // Build the result transaction
    always_comb begin
        o_push_data = '0;
        if (r_state == S_SUM) begin
            o_push_data.is_summary   = 1'b1;
            o_push_data.season_count = r_found;
            o_push_data.all_null     = r_nulls;
            o_push_data.last_result  = 1'b1;
        end else begin
            o_push_data.season_index   = r_found[3:0];
            o_push_data.start_core     = r_ts1;
            o_push_data.start_extended = r_ts2;
            o_push_data.end_core       = r_te1;
            o_push_data.end_extended   = r_te2;
        end
        o_push = (r_state == S_SUM) || ((r_state == S_EMIT) && season_ok);
        o_done = (r_state == S_SUM) && i_push_ready;
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (i_start.go) begin
                    r_state <= (CW'(i_start.n) < CW'(2)) ? S_SUM : S_P0;
                end
                S_P0:    r_state <= S_P1;
                S_P1:    r_state <= S_P2;
                S_P2:    r_state <= S_P3;
                S_P3:    r_state <= S_P4;
                S_P4:    r_state <= S_C_LD;
                S_C_LD:  r_state <= (r_i0 >= r_n) ? S_SUM : S_C_CAP;
                S_C_CAP: r_state <= S_C_RD;
                S_C_RD:  r_state <= S_C_EV;
                S_C_EV:  r_state <= hit ? S_B_LD : (last_i ? S_SUM : S_C_RD);
                S_B_LD:  r_state <= (r_s1 == r_i0) ? S_F_LD : S_B_CAP;
                S_B_CAP: r_state <= S_B_RD;
                S_B_RD:  r_state <= S_B_EV;
                S_B_EV:  r_state <= (stopb || r_i == r_i0) ? S_F_LD : S_B_RD;
                S_F_LD:  r_state <= (r_e1 + 1'b1 >= r_n) ? S_EMIT : S_F_CAP;
                S_F_CAP: r_state <= S_F_RD;
                S_F_RD:  r_state <= S_F_EV;
                S_F_EV:  r_state <= (stopf || last_i) ? S_EMIT : S_F_RD;
                S_EMIT:  if (!season_ok || i_push_ready) begin
                    r_state <= S_C_LD;
                end
                S_SUM:   if (i_push_ready) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath updates
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n     <= CW'(i_start.n);
                r_nulls <= i_start.all_null;
                r_found <= '0;
                r_i0    <= '0;
            end
            S_P1: r_t0 <= r_rd_t;
            S_P2: r_e0 <= sx(r_t0) + sx(r_t0) + sx(r_t0) - sx(r_rd_t);
            S_P3: r_tl <= r_rd_t;
            S_P4: r_el <= sx(r_tl) + sx(r_tl) + sx(r_tl) - sx(r_rd_t);
            S_C_CAP, S_B_CAP, S_F_CAP: begin
                r_cur_v  <= r_rd_v;
                r_cur_t  <= r_rd_t;
                r_cur_nl <= r_rd_nl;
                r_run    <= 1'b0;
                r_gap    <= 1'b0;
                if (r_state == S_C_CAP) begin
                    r_aux_t <= r_te2;
                    r_i     <= r_i0;
                end else if (r_state == S_B_CAP) begin
                    r_aux_t <= r_ts1;
                    r_i     <= r_s1 - 1'b1;
                end else begin
                    r_aux_t <= r_te1;
                    r_i     <= r_e1 + 1'b1;
                end
            end
            S_C_EV: begin
                if (ins) begin
                    if (!r_run) begin
                        r_s1  <= r_i;
                        r_ts1 <= r_cur_t;
                        r_run <= 1'b1;
                    end
                    r_mark <= mark_c;
                    r_e1   <= r_i;
                    r_te1  <= r_cur_t;
                end else begin
                    r_run <= 1'b0;
                end
                r_aux_t  <= r_cur_t;
                r_cur_v  <= r_rd_v;
                r_cur_t  <= r_rd_t;
                r_cur_nl <= r_rd_nl;
                r_i      <= r_i + 1'b1;
            end
            S_B_LD: r_ts2 <= r_ts1;
            S_B_EV: begin
                if (ins) begin
                    r_gap <= 1'b0;
                    r_ts2 <= r_cur_t;
                end else begin
                    r_gap  <= 1'b1;
                    r_mark <= mark_b;
                end
                r_aux_t  <= r_cur_t;
                r_cur_v  <= r_rd_v;
                r_cur_t  <= r_rd_t;
                r_cur_nl <= r_rd_nl;
                r_i      <= r_i - 1'b1;
            end
            S_F_LD: begin
                r_e2  <= r_e1;
                r_te2 <= r_te1;
            end
            S_F_EV: begin
                if (ins) begin
                    r_gap <= 1'b0;
                    r_e2  <= r_i;
                    r_te2 <= r_cur_t;
                end else begin
                    r_gap  <= 1'b1;
                    r_mark <= mark_f;
                end
                r_aux_t  <= r_cur_t;
                r_cur_v  <= r_rd_v;
                r_cur_t  <= r_rd_t;
                r_cur_nl <= r_rd_nl;
                r_i      <= r_i + 1'b1;
            end
            S_EMIT: if (!season_ok || i_push_ready) begin
                r_found <= (r_found == CNT_SAT) ? r_found : r_found + 1'b1;
                r_i0    <= r_e2 + 1'b1;
            end
            default: ;
        endcase
    end

    a_core_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_C_EV) |-> (r_i < r_n)) else $error("core scan past series end");
    a_back_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B_EV) |-> (r_i >= r_i0 && r_i < r_s1)) else $error("backward scan out of range");
    a_sum_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && i_push_ready) |=> (r_state == S_IDLE)) else $error("summary not final");

endmodule
